// ===== rtl/psc_pkg.sv =====
// Shared types and codes for the polymorphic shape cache.
// No dependencies; psc_ctrl, psc_datapath and the top level refer to it by scoped names.
package psc_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  localparam logic [1:0] MODE_EMPTY  = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_MULTI  = 2'd2;
  localparam logic [1:0] MODE_OVER   = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] shape_key;
    logic [15:0] new_offset;
  } item_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] found_offset;
    logic [1:0]  cache_mode;
    logic [63:0] hit_count;
    logic [63:0] miss_count;
  } result_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

// ===== rtl/psc_if.sv =====
// Valid/ready channel interfaces for requests and responses of the shape cache.
// Stand-alone; field widths follow the request and response layouts in psc_pkg.
interface psc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] shape_key;
  logic [15:0] new_offset;

  modport source (output valid, op, shape_key, new_offset, input ready);
  modport sink   (input valid, op, shape_key, new_offset, output ready);
endinterface

interface psc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [15:0] found_offset;
  logic [1:0]  cache_mode;
  logic [63:0] hit_count;
  logic [63:0] miss_count;

  modport source (output valid, hit, found_offset, cache_mode, hit_count, miss_count,
                  input ready);
  modport sink   (input valid, hit, found_offset, cache_mode, hit_count, miss_count,
                  output ready);
endinterface

// ===== rtl/psc_ctrl.sv =====
// Controller of the shape cache: takes a request, schedules its execution and
// holds the response valid until transfer. Depends on psc_pkg.
module psc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output psc_pkg::cmd_t cmd
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;
  logic   ready;
  logic   out_valid;

  assign req_ready = ready;
  assign rsp_valid = out_valid;
  assign cmd.load  = (state == IDLE) && ready && req_valid;
  assign cmd.exec  = (state == EXEC) && (!out_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      ready     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_valid && ready) begin
            state <= EXEC;
            ready <= 1'b0;
          end
        end
        EXEC: begin
          if (!out_valid || rsp_ready) begin
            state <= IDLE;
            ready <= 1'b1;
          end
        end
        default: begin
          state <= IDLE;
          ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/psc_datapath.sv =====
// Datapath of the shape cache: entry stores, parallel key compare, mode and
// fill tracking, hit/miss counters and the response register. Depends on psc_pkg.
module psc_datapath #(
  parameter int WAYS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  psc_pkg::cmd_t    cmd,
  input  psc_pkg::item_t   item,
  output psc_pkg::result_t result
);

  localparam int IDX_W = $clog2(WAYS);
  localparam int CNT_W = $clog2(WAYS + 1);

  psc_pkg::item_t   item_q;
  psc_pkg::result_t result_q;
  logic [31:0]      key_mem [WAYS];
  logic [15:0]      off_mem [WAYS];
  logic [CNT_W-1:0] fill;
  logic [1:0]       mode;
  logic [63:0]      hits;
  logic [63:0]      misses;

  logic             any_match;
  logic [IDX_W-1:0] match_idx;
  logic             live;
  logic             hit_next;
  logic [15:0]      found_next;
  logic [CNT_W-1:0] fill_next;
  logic [1:0]       mode_next;
  logic [63:0]      hits_next;
  logic [63:0]      misses_next;
  logic             wr_en;
  logic [IDX_W-1:0] wr_slot;

  assign result = result_q;
  assign live   = (mode == psc_pkg::MODE_SINGLE) || (mode == psc_pkg::MODE_MULTI);

  always_comb begin
    any_match = 1'b0;
    match_idx = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < fill) && (key_mem[i] == item_q.shape_key)) begin
        any_match = 1'b1;
        match_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    hit_next    = 1'b0;
    found_next  = '0;
    fill_next   = fill;
    mode_next   = mode;
    hits_next   = hits;
    misses_next = misses;
    wr_en       = 1'b0;
    wr_slot     = '0;
    case (item_q.op)
      psc_pkg::OP_LOOKUP: begin
        if (live && any_match) begin
          hit_next   = 1'b1;
          found_next = off_mem[match_idx];
          hits_next  = hits + 64'd1;
        end else begin
          misses_next = misses + 64'd1;
        end
      end
      psc_pkg::OP_UPDATE: begin
        if (mode == psc_pkg::MODE_EMPTY) begin
          wr_en     = 1'b1;
          wr_slot   = '0;
          fill_next = CNT_W'(1);
          mode_next = psc_pkg::MODE_SINGLE;
        end else if (live && !any_match) begin
          if (fill < CNT_W'(WAYS)) begin
            wr_en     = 1'b1;
            wr_slot   = fill[IDX_W-1:0];
            fill_next = fill + CNT_W'(1);
            mode_next = psc_pkg::MODE_MULTI;
          end else begin
            mode_next = psc_pkg::MODE_OVER;
          end
        end
      end
      psc_pkg::OP_FLUSH: begin
        fill_next   = '0;
        mode_next   = psc_pkg::MODE_EMPTY;
        hits_next   = '0;
        misses_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    if (cmd.exec) begin
      result_q.hit          <= hit_next;
      result_q.found_offset <= found_next;
      result_q.cache_mode   <= mode_next;
      result_q.hit_count    <= hits_next;
      result_q.miss_count   <= misses_next;
      if (wr_en) begin
        key_mem[wr_slot] <= item_q.shape_key;
        off_mem[wr_slot] <= item_q.new_offset;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      mode   <= psc_pkg::MODE_EMPTY;
      hits   <= '0;
      misses <= '0;
    end else if (cmd.exec) begin
      fill   <= fill_next;
      mode   <= mode_next;
      hits   <= hits_next;
      misses <= misses_next;
    end
  end

endmodule

// ===== rtl/polymorphic_shape_cache.sv =====
// Top level of the polymorphic shape cache: controller, datapath and channel glue.
// Depends on psc_pkg, psc_if, psc_ctrl and psc_datapath.
//
//   channel  dir  fields                                              handshake
//   req      in   op, shape_key, new_offset                           valid/ready
//   rsp      out  hit, found_offset, cache_mode, hit_count, miss_count valid/ready
//
// Each request is first registered, then its key is compared against all WAYS
// entries in parallel and the stores and counters are updated.
// A new request is taken while the previous response still waits; execution
// stalls only while the response register is full and rsp.ready is low.
// Synchronous reset empties the cache and clears both counters at once.
module polymorphic_shape_cache #(
  parameter int WAYS = 4
) (
  input logic     clk,
  input logic     rst,
  psc_req_if.sink   req,
  psc_rsp_if.source rsp
);

  psc_pkg::cmd_t    cmd;
  psc_pkg::item_t   item;
  psc_pkg::result_t result;

  assign item.op         = req.op;
  assign item.shape_key  = req.shape_key;
  assign item.new_offset = req.new_offset;

  assign rsp.hit          = result.hit;
  assign rsp.found_offset = result.found_offset;
  assign rsp.cache_mode   = result.cache_mode;
  assign rsp.hit_count    = result.hit_count;
  assign rsp.miss_count   = result.miss_count;

  psc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  psc_datapath #(
    .WAYS (WAYS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .result (result)
  );

  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in flight");

  assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (!rsp.valid || rsp.ready))
    else $error("execution overwrote a response not yet transferred");

  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.exec))
    else $error("response appeared without an execution");

  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.hit) |->
      (rsp.cache_mode == psc_pkg::MODE_SINGLE || rsp.cache_mode == psc_pkg::MODE_MULTI))
    else $error("hit reported from an empty or overflowed cache");

  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.hit) |-> (rsp.found_offset == 16'd0))
    else $error("nonzero offset on a miss");

endmodule
